/* sv/gle_pkg.sv */
// Shared constants for the GIF LZW encoder.
// No dependencies; used by gif_lzw_encoder.
package gle_pkg;
   localparam int MAX_CODE_BITS_DEF   = 12;
   localparam int HASH_SLOT_COUNT_DEF = 8192;
   localparam logic [31:0] HASH_GOLDEN = 32'h9E37_79B1;
   localparam logic [3:0] MIN_BITS_RESET = 4'd8;
   localparam logic [3:0] MIN_BITS_LO    = 4'd2;
   localparam logic [3:0] MIN_BITS_HI    = 4'd8;
endpackage

/* sv/gle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* sv/gif_lzw_encoder.sv */
// GIF variable-width LZW encoder top level: sequencer, bit packer, output register.
// Depends on gle_pkg and gle_ram (dictionary and hash slot memories).
//
// Takes one pixel beat at a time and emits the LSB-first packed LZW code stream
// as byte beats, last_byte flagging the final byte of an image. A pixel that
// extends the current string goes through accept, dispatch, forming the hash,
// one hash probe (slot read, dictionary read, compare) and the finish. Each
// probe that hits an occupied slot with another key adds another probe.
// A pixel that ends a string goes through the probe that finds an empty slot,
// the decision, packing the code, draining each output byte and leaving the
// drain, hashing the new entry, the insert probes when an entry is added, the
// width update, the string restart and the finish. Every clear code (image
// start and full table) is followed by a pass over the hash slot memory, one
// slot a cycle, through all HASH_SLOT_COUNT slots (8192 by default), during
// which no pixel is taken.
// min_code_bits is sampled at the first pixel of each image; values outside
// 2..8 are clamped. The output register lets the sequencer run on while the
// last byte waits; the sequencer waits only when a new byte finds it full.
module gif_lzw_encoder #(
   parameter int MAX_CODE_BITS   = gle_pkg::MAX_CODE_BITS_DEF,
   parameter int HASH_SLOT_COUNT = gle_pkg::HASH_SLOT_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_pixel,
   input  logic       req_last_pixel,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_byte,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_min_code_bits
);
   localparam int CW    = MAX_CODE_BITS;
   localparam int NFW   = CW + 1;
   localparam int HB    = $clog2(HASH_SLOT_COUNT);
   localparam int KEYW  = 20;
   localparam int DW    = CW + 8;
   localparam int BUFW  = CW + 8;
   localparam int CNTW  = $clog2(BUFW + 1);
   localparam logic [HB-1:0]  HMUL      = HB'(gle_pkg::HASH_GOLDEN);
   localparam logic [NFW-1:0] DICT_SIZE = {1'b1, {CW{1'b0}}};

   // encoder phases
   localparam logic [1:0] PH_BEFORE = 2'd0;
   localparam logic [1:0] PH_AFTER  = 2'd1;
   localparam logic [1:0] PH_NORMAL = 2'd2;

   // sequencer states
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_TOP    = 5'd1;
   localparam logic [4:0] S_SWEEP  = 5'd2;
   localparam logic [4:0] S_LOOK   = 5'd3;
   localparam logic [4:0] S_PRB_A  = 5'd4;
   localparam logic [4:0] S_PRB_B  = 5'd5;
   localparam logic [4:0] S_PRB_C  = 5'd6;
   localparam logic [4:0] S_DECIDE = 5'd7;
   localparam logic [4:0] S_ADD    = 5'd8;
   localparam logic [4:0] S_INS_A  = 5'd9;
   localparam logic [4:0] S_INS_B  = 5'd10;
   localparam logic [4:0] S_UPD    = 5'd11;
   localparam logic [4:0] S_TAIL   = 5'd12;
   localparam logic [4:0] S_END    = 5'd13;
   localparam logic [4:0] S_FIN2   = 5'd14;
   localparam logic [4:0] S_FIN3   = 5'd15;
   localparam logic [4:0] S_FIN4   = 5'd16;
   localparam logic [4:0] S_PUT    = 5'd17;
   localparam logic [4:0] S_DRAIN  = 5'd18;
   localparam logic [4:0] S_DONE   = 5'd19;

   logic [4:0]      state_ff, state_in, ret_ff, ret_in;
   logic [3:0]      csr_bits_ff, csr_bits_in;
   logic [3:0]      img_bits_ff, img_bits_in;
   logic [3:0]      width_ff, width_in;
   logic [NFW-1:0]  nfree_ff, nfree_in;
   logic [CW-1:0]   cur_ff, cur_in, prev_ff, prev_in, put_ff, put_in;
   logic [CW-1:0]   slot_ff, slot_in;
   logic            cur_valid_ff, cur_valid_in;
   logic [7:0]      first_ff, first_in, pix_ff, pix_in;
   logic            last_ff, last_in;
   logic [1:0]      phase_ff, phase_in;
   logic            in_image_ff, in_image_in;
   logic            fin_ff, fin_in, endm_ff, endm_in, kw_ff, kw_in;
   logic [BUFW-1:0] buf_ff, buf_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [HB-1:0]   hash_ff, hash_in, sweep_ff, sweep_in;
   logic            ovalid_ff, ovalid_in, olast_ff, olast_in;
   logic [7:0]      obyte_ff, obyte_in;

   // memory ports
   logic            hs_we, dc_we;
   logic [HB-1:0]   hs_waddr;
   logic [CW-1:0]   hs_wdata, hs_rdata;
   logic [DW-1:0]   dc_wdata, dc_rdata;

   // shared hash unit: key chain/emit -> slot index
   logic [CW-1:0]        hk_chain;
   logic [7:0]           hk_emit;
   logic [KEYW-1:0]      hk_key;
   logic [HB-1:0]        hk_prod;
   logic [CW-1:0]        code_mask, clr_code;
   logic [3:0]           csr_clamped;
   logic                 kw, out_free, emit_ok;

   gle_ram #(.WIDTH(CW), .DEPTH(HASH_SLOT_COUNT)) u_hash_ram (
      .clock(clock), .wr_en(hs_we), .wr_addr(hs_waddr), .wr_data(hs_wdata),
      .rd_addr(hash_ff), .rd_data(hs_rdata)
   );

   gle_ram #(.WIDTH(DW), .DEPTH(1 << CW)) u_dict_ram (
      .clock(clock), .wr_en(dc_we), .wr_addr(nfree_ff[CW-1:0]), .wr_data(dc_wdata),
      .rd_addr(hs_rdata), .rd_data(dc_rdata)
   );

   // slot index is the product modulo the slot count: only the low HB bits matter
   assign hk_key    = {12'(hk_chain), hk_emit};
   assign hk_prod   = HB'(hk_key) * HMUL;
   assign code_mask = ~({CW{1'b1}} << width_ff);
   assign clr_code  = CW'(1) << img_bits_ff;
   assign out_free  = !ovalid_ff || !rsp_stall;
   assign kw = (phase_ff == PH_NORMAL) && cur_valid_ff && (cur_ff == prev_ff) &&
               (first_ff == pix_ff);
   assign emit_ok = endm_ff ? (cnt_ff != '0) : (cnt_ff >= CNTW'(8));

   always_comb begin
      priority if (csr_bits_ff < gle_pkg::MIN_BITS_LO) begin
         csr_clamped = gle_pkg::MIN_BITS_LO;
      end else if (csr_bits_ff > gle_pkg::MIN_BITS_HI) begin
         csr_clamped = gle_pkg::MIN_BITS_HI;
      end else begin
         csr_clamped = csr_bits_ff;
      end
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = ovalid_ff;
   assign rsp_out_byte  = obyte_ff;
   assign rsp_last_byte = olast_ff;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      csr_bits_in  = (csr_valid && csr_ready) ? csr_min_code_bits : csr_bits_ff;
      img_bits_in  = img_bits_ff;
      width_in     = width_ff;
      nfree_in     = nfree_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      put_in       = put_ff;
      slot_in      = slot_ff;
      cur_valid_in = cur_valid_ff;
      first_in     = first_ff;
      pix_in       = pix_ff;
      last_in      = last_ff;
      phase_in     = phase_ff;
      in_image_in  = in_image_ff;
      fin_in       = fin_ff;
      endm_in      = endm_ff;
      kw_in        = kw_ff;
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      hash_in      = hash_ff;
      sweep_in     = sweep_ff;
      ovalid_in    = ovalid_ff && rsp_stall;
      olast_in     = olast_ff;
      obyte_in     = obyte_ff;
      hs_we        = 1'b0;
      hs_waddr     = hash_ff;
      hs_wdata     = '0;
      dc_we        = 1'b0;
      dc_wdata     = {prev_ff, first_ff};
      hk_chain     = cur_ff;
      hk_emit      = pix_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pix_in   = req_pixel;
               last_in  = req_last_pixel;
               if (!in_image_ff) begin
                  img_bits_in = csr_clamped;
                  width_in    = csr_clamped + 4'd1;
                  in_image_in = 1'b1;
               end
               state_in = S_TOP;
            end
         end
         S_TOP: begin
            if (phase_ff == PH_BEFORE) begin
               // clear code goes out at the old width, then the slots are wiped
               put_in   = clr_code;
               ret_in   = S_SWEEP;
               sweep_in = '0;
               state_in = S_PUT;
            end else begin
               state_in = fin_ff ? S_FIN2 : S_LOOK;
            end
         end
         S_SWEEP: begin
            hs_we    = 1'b1;
            hs_waddr = sweep_ff;
            sweep_in = sweep_ff + HB'(1);
            if (sweep_ff == {HB{1'b1}}) begin
               nfree_in     = NFW'(clr_code) + NFW'(2);
               width_in     = img_bits_ff + 4'd1;
               phase_in     = PH_AFTER;
               cur_valid_in = 1'b0;
               state_in     = fin_ff ? S_FIN2 : S_LOOK;
            end
         end
         S_LOOK: begin
            hash_in  = hk_prod;
            state_in = cur_valid_ff ? S_PRB_A : S_DECIDE;
         end
         S_PRB_A: state_in = S_PRB_B;
         S_PRB_B: begin
            slot_in  = hs_rdata;
            state_in = (hs_rdata == '0) ? S_DECIDE : S_PRB_C;
         end
         S_PRB_C: begin
            if (dc_rdata == {cur_ff, pix_ff}) begin
               cur_in   = slot_ff;
               state_in = S_END;
            end else begin
               hash_in  = hash_ff + HB'(1);
               state_in = S_PRB_A;
            end
         end
         S_DECIDE: begin
            kw_in = kw;
            if (kw) begin
               cur_in = nfree_ff[CW-1:0];
            end
            if (cur_valid_ff || kw) begin
               put_in   = kw ? nfree_ff[CW-1:0] : cur_ff;
               ret_in   = S_ADD;
               state_in = S_PUT;
            end else begin
               state_in = S_TAIL;
            end
         end
         S_ADD: begin
            hk_chain = prev_ff;
            hk_emit  = first_ff;
            hash_in  = hk_prod;
            if (phase_ff == PH_NORMAL && nfree_ff < DICT_SIZE) begin
               dc_we    = 1'b1;
               state_in = S_INS_A;
            end else begin
               state_in = S_UPD;
            end
         end
         S_INS_A: state_in = S_INS_B;
         S_INS_B: begin
            if (hs_rdata == '0) begin
               hs_we    = 1'b1;
               hs_wdata = nfree_ff[CW-1:0];
               nfree_in = nfree_ff + NFW'(1);
               state_in = S_UPD;
            end else begin
               hash_in  = hash_ff + HB'(1);
               state_in = S_INS_A;
            end
         end
         S_UPD: begin
            phase_in = PH_NORMAL;
            if (nfree_ff >= (NFW'(1) << width_ff)) begin
               if (width_ff < 4'(MAX_CODE_BITS)) begin
                  width_in = width_ff + 4'd1;
               end else begin
                  phase_in = PH_BEFORE;
               end
            end
            prev_in  = cur_ff;
            state_in = S_TAIL;
         end
         S_TAIL: begin
            priority if (kw_ff) begin
               cur_valid_in = 1'b0;
               state_in     = S_END;
            end else if (phase_ff == PH_BEFORE) begin
               cur_valid_in = 1'b0;
               state_in     = S_TOP;
            end else begin
               cur_in       = CW'(pix_ff);
               first_in     = pix_ff;
               cur_valid_in = 1'b1;
               state_in     = S_END;
            end
            kw_in = 1'b0;
         end
         S_END: begin
            if (last_ff) begin
               fin_in   = 1'b1;
               state_in = S_TOP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FIN2: begin
            if (cur_valid_ff) begin
               put_in   = cur_ff;
               ret_in   = S_FIN3;
               state_in = S_PUT;
            end else begin
               state_in = S_FIN4;
            end
         end
         S_FIN3: begin
            // match the decoder's width bump before the end code
            if (phase_ff == PH_NORMAL && nfree_ff < DICT_SIZE &&
                (nfree_ff + NFW'(1)) >= (NFW'(1) << width_ff) &&
                width_ff < 4'(MAX_CODE_BITS)) begin
               width_in = width_ff + 4'd1;
            end
            state_in = S_FIN4;
         end
         S_FIN4: begin
            put_in   = clr_code + CW'(1);
            endm_in  = 1'b1;
            ret_in   = S_DONE;
            state_in = S_PUT;
         end
         S_PUT: begin
            buf_in   = buf_ff | (BUFW'(put_ff & code_mask) << cnt_ff);
            cnt_in   = cnt_ff + CNTW'(width_ff);
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!emit_ok) begin
               state_in = ret_ff;
            end else if (out_free) begin
               ovalid_in = 1'b1;
               obyte_in  = buf_ff[7:0];
               olast_in  = endm_ff && (cnt_ff <= CNTW'(8));
               buf_in    = buf_ff >> 8;
               cnt_in    = (cnt_ff >= CNTW'(8)) ? cnt_ff - CNTW'(8) : '0;
            end
         end
         S_DONE: begin
            buf_in       = '0;
            cnt_in       = '0;
            cur_valid_in = 1'b0;
            phase_in     = PH_BEFORE;
            in_image_in  = 1'b0;
            fin_in       = 1'b0;
            endm_in      = 1'b0;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         csr_bits_ff  <= gle_pkg::MIN_BITS_RESET;
         img_bits_ff  <= gle_pkg::MIN_BITS_RESET;
         width_ff     <= gle_pkg::MIN_BITS_RESET + 4'd1;
         nfree_ff     <= (NFW'(1) << gle_pkg::MIN_BITS_RESET) + NFW'(2);
         cur_valid_ff <= 1'b0;
         first_ff     <= '0;
         phase_ff     <= PH_BEFORE;
         in_image_ff  <= 1'b0;
         fin_ff       <= 1'b0;
         endm_ff      <= 1'b0;
         kw_ff        <= 1'b0;
         buf_ff       <= '0;
         cnt_ff       <= '0;
         ovalid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         csr_bits_ff  <= csr_bits_in;
         img_bits_ff  <= img_bits_in;
         width_ff     <= width_in;
         nfree_ff     <= nfree_in;
         cur_valid_ff <= cur_valid_in;
         first_ff     <= first_in;
         phase_ff     <= phase_in;
         in_image_ff  <= in_image_in;
         fin_ff       <= fin_in;
         endm_ff      <= endm_in;
         kw_ff        <= kw_in;
         buf_ff       <= buf_in;
         cnt_ff       <= cnt_in;
         ovalid_ff    <= ovalid_in;
      end
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      put_ff   <= put_in;
      slot_ff  <= slot_in;
      pix_ff   <= pix_in;
      last_ff  <= last_in;
      hash_ff  <= hash_in;
      sweep_ff <= sweep_in;
      olast_ff <= olast_in;
      obyte_ff <= obyte_in;
   end

   // between pixels the packer never holds a full byte
   a_idle_partial: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> cnt_ff < CNTW'(8))
      else $error("whole byte left in bit buffer at idle");

   // code width stays between 3 and MAX_CODE_BITS
   a_width_range: assert property (@(posedge clock) disable iff (reset)
      width_ff >= 4'd3 && width_ff <= 4'(MAX_CODE_BITS))
      else $error("code width out of range");

   // free code counter never passes the table size
   a_nfree_max: assert property (@(posedge clock) disable iff (reset)
      nfree_ff <= DICT_SIZE)
      else $error("free code counter overran the table");

   // the done state closes the image: phase back to before, bit buffer empty
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> !in_image_ff && phase_ff == PH_BEFORE && cnt_ff == '0)
      else $error("image end left encoder state behind");
endmodule
